### rtl/sro_pkg.sv
// ----------------------------------------------------------------------------
// sro_pkg
// shared widths, status codes and store entry type for the reorder buffer
// ----------------------------------------------------------------------------
package sro_pkg;

  localparam int SEQ_W         = 32;
  localparam int HANDLE_W      = 16;
  localparam int LENGTH_W      = 16;
  localparam int STATUS_W      = 3;
  localparam int HOLD_DEPTH_DEF = 16;

  typedef enum logic [STATUS_W-1:0] {
    ST_RELEASED = 3'd0,
    ST_STALE    = 3'd1,
    ST_HELD     = 3'd2,
    ST_DUP      = 3'd3,
    ST_FULL     = 3'd4
  } status_t;

  typedef struct packed {
    logic [SEQ_W-1:0]    seq;
    logic [HANDLE_W-1:0] handle;
    logic [LENGTH_W-1:0] length;
  } hold_entry_t;

  typedef struct packed {
    logic wr_en;
    logic clr_en;
  } hold_ctl_t;

endpackage

### rtl/sro_in_if.sv
// ----------------------------------------------------------------------------
// sro_in_if
// arriving message channel: sequence number and payload descriptor
// ----------------------------------------------------------------------------
interface sro_in_if import sro_pkg::*; ();

  logic                valid;
  logic                ready;
  logic [SEQ_W-1:0]    seq_number;
  logic [HANDLE_W-1:0] payload_handle;
  logic [LENGTH_W-1:0] payload_length;

  modport source (
    output valid, seq_number, payload_handle, payload_length,
    input  ready
  );

  modport sink (
    input  valid, seq_number, payload_handle, payload_length,
    output ready
  );

endinterface

### rtl/sro_out_if.sv
// ----------------------------------------------------------------------------
// sro_out_if
// result channel: one transaction per result row
// ----------------------------------------------------------------------------
interface sro_out_if import sro_pkg::*; ();

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [HANDLE_W-1:0] out_handle;
  logic [LENGTH_W-1:0] out_length;
  logic [SEQ_W-1:0]    out_seq;
  logic [SEQ_W-1:0]    acked_through;
  logic                last;

  modport source (
    output valid, status, out_handle, out_length, out_seq, acked_through, last,
    input  ready
  );

  modport sink (
    input  valid, status, out_handle, out_length, out_seq, acked_through, last,
    output ready
  );

endinterface

### rtl/sro_hold_store.sv
// ----------------------------------------------------------------------------
// sro_hold_store
// holding store: entry memory with registered read, per-slot valid bits
// ----------------------------------------------------------------------------
module sro_hold_store import sro_pkg::*; #(
  parameter int HOLD_DEPTH = HOLD_DEPTH_DEF,
  parameter int IDX_W      = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [IDX_W-1:0] rd_idx,
  input  hold_ctl_t        ctl,
  input  logic [IDX_W-1:0] wr_idx,
  input  hold_entry_t      wr_entry,
  output hold_entry_t      rd_entry,
  output logic             rd_valid
);

  hold_entry_t           mem [HOLD_DEPTH];
  logic [HOLD_DEPTH-1:0] valid_r;
  hold_entry_t           rd_entry_r;
  logic                  rd_valid_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_idx] <= wr_entry;
    end
    rd_entry_r <= mem[rd_idx];
    rd_valid_r <= valid_r[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (ctl.wr_en) begin
      valid_r[wr_idx] <= 1'b1;
    end else if (ctl.clr_en) begin
      valid_r[wr_idx] <= 1'b0;
    end
  end

  assign rd_entry = rd_entry_r;
  assign rd_valid = rd_valid_r;

endmodule

### rtl/sequence_reorder_buffer.sv
// ----------------------------------------------------------------------------
// sequence_reorder_buffer
// receive-side reorder buffer giving in-order delivery of sequenced messages
// ----------------------------------------------------------------------------
// in_chan carries one message per transaction: sequence number plus payload
// handle and length. out_chan carries result rows; last marks the final row
// of each message. A stale repeat, a newly held, an already held or a
// dropped message gives one row; the expected number gives a released row
// followed by one row per held entry that now follows in order.
// Messages are taken one at a time; in_chan.ready is high only while idle.
// A stale message needs no sweep. Every other message needs a sweep
// of the holding store through its single read port, one slot per cycle;
// the sweep for a duplicate stops at the match, and a release that
// drains n entries sweeps the store again after each one.
// A result row sits in an output register; the next message is accepted
// while it waits. When out_chan stalls the sweep pauses before it would
// overwrite that register, so no row is lost.
// After reset the expected number is zero and all slots are free.
// ----------------------------------------------------------------------------
module sequence_reorder_buffer import sro_pkg::*; #(
  parameter int HOLD_DEPTH = HOLD_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  sro_in_if.sink    in_chan,
  sro_out_if.source out_chan
);

  localparam int IDX_W = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(HOLD_DEPTH - 1);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_CLASS = 5'b00010,
    S_SCAN  = 5'b00100,
    S_DRAIN = 5'b01000,
    S_EMIT  = 5'b10000
  } state_t;

  state_t              state_r, state_nxt;
  logic [SEQ_W-1:0]    expected_r, expected_nxt;
  logic [SEQ_W-1:0]    seq_r, seq_nxt;
  logic [HANDLE_W-1:0] handle_r, handle_nxt;
  logic [LENGTH_W-1:0] length_r, length_nxt;
  logic                drain_mode_r, drain_mode_nxt;
  logic [IDX_W-1:0]    scan_idx_r, scan_idx_nxt;
  logic                scan_on_r, scan_on_nxt;
  logic                cmp_vld_r, cmp_vld_nxt;
  logic [IDX_W-1:0]    cmp_idx_r, cmp_idx_nxt;
  logic                free_found_r, free_found_nxt;
  logic [IDX_W-1:0]    free_idx_r, free_idx_nxt;
  hold_entry_t         hit_r, hit_nxt;
  logic [IDX_W-1:0]    hit_slot_r, hit_slot_nxt;
  status_t             res_status_r, res_status_nxt;
  logic [HANDLE_W-1:0] res_handle_r, res_handle_nxt;
  logic [LENGTH_W-1:0] res_length_r, res_length_nxt;
  logic [SEQ_W-1:0]    res_seq_r, res_seq_nxt;
  logic [SEQ_W-1:0]    res_acked_r, res_acked_nxt;
  logic                out_valid_r, out_valid_nxt;
  status_t             out_status_r, out_status_nxt;
  logic [HANDLE_W-1:0] out_handle_r, out_handle_nxt;
  logic [LENGTH_W-1:0] out_length_r, out_length_nxt;
  logic [SEQ_W-1:0]    out_seq_r, out_seq_nxt;
  logic [SEQ_W-1:0]    out_acked_r, out_acked_nxt;
  logic                out_last_r, out_last_nxt;

  hold_ctl_t           store_ctl;
  logic [IDX_W-1:0]    store_wr_idx;
  hold_entry_t         store_wr_entry;
  hold_entry_t         rd_entry;
  logic                rd_valid;

  logic [SEQ_W-1:0]    key;
  logic                hit;
  logic                scan_end;
  logic                free_now;
  logic [IDX_W-1:0]    free_slot;
  logic                out_free;

  sro_hold_store #(
    .HOLD_DEPTH (HOLD_DEPTH),
    .IDX_W      (IDX_W)
  ) u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_idx   (scan_idx_r),
    .ctl      (store_ctl),
    .wr_idx   (store_wr_idx),
    .wr_entry (store_wr_entry),
    .rd_entry (rd_entry),
    .rd_valid (rd_valid)
  );

  assign key       = drain_mode_r ? expected_r : seq_r;
  assign hit       = cmp_vld_r && rd_valid && (rd_entry.seq == key);
  assign scan_end  = cmp_vld_r && !hit && (cmp_idx_r == LAST_IDX);
  assign free_now  = free_found_r || (cmp_vld_r && !rd_valid);
  assign free_slot = free_found_r ? free_idx_r : cmp_idx_r;
  assign out_free  = !out_valid_r || out_chan.ready;

  assign store_wr_entry = '{seq: seq_r, handle: handle_r, length: length_r};

  always_comb begin
    state_nxt      = state_r;
    expected_nxt   = expected_r;
    seq_nxt        = seq_r;
    handle_nxt     = handle_r;
    length_nxt     = length_r;
    drain_mode_nxt = drain_mode_r;
    scan_idx_nxt   = scan_idx_r;
    scan_on_nxt    = scan_on_r;
    cmp_vld_nxt    = 1'b0;
    cmp_idx_nxt    = cmp_idx_r;
    free_found_nxt = free_found_r;
    free_idx_nxt   = free_idx_r;
    hit_nxt        = hit_r;
    hit_slot_nxt   = hit_slot_r;
    res_status_nxt = res_status_r;
    res_handle_nxt = res_handle_r;
    res_length_nxt = res_length_r;
    res_seq_nxt    = res_seq_r;
    res_acked_nxt  = res_acked_r;
    out_valid_nxt  = out_valid_r && !out_chan.ready;
    out_status_nxt = out_status_r;
    out_handle_nxt = out_handle_r;
    out_length_nxt = out_length_r;
    out_seq_nxt    = out_seq_r;
    out_acked_nxt  = out_acked_r;
    out_last_nxt   = out_last_r;
    store_ctl      = '0;
    store_wr_idx   = free_slot;

    case (state_r)
      S_IDLE: begin
        if (in_chan.valid) begin
          seq_nxt    = in_chan.seq_number;
          handle_nxt = in_chan.payload_handle;
          length_nxt = in_chan.payload_length;
          state_nxt  = S_CLASS;
        end
      end

      S_CLASS: begin
        res_handle_nxt = '0;
        res_length_nxt = '0;
        res_seq_nxt    = '0;
        res_acked_nxt  = expected_r - SEQ_W'(1);
        if (seq_r < expected_r) begin
          res_status_nxt = ST_STALE;
          state_nxt      = S_EMIT;
        end else begin
          // both remaining cases sweep the store
          scan_idx_nxt   = '0;
          scan_on_nxt    = 1'b1;
          free_found_nxt = 1'b0;
          state_nxt      = S_SCAN;
          if (seq_r == expected_r) begin
            res_status_nxt = ST_RELEASED;
            res_handle_nxt = handle_r;
            res_length_nxt = length_r;
            res_seq_nxt    = seq_r;
            res_acked_nxt  = seq_r;
            expected_nxt   = expected_r + SEQ_W'(1);
            drain_mode_nxt = 1'b1;
          end else begin
            drain_mode_nxt = 1'b0;
          end
        end
      end

      S_SCAN: begin
        if (scan_on_r) begin
          scan_idx_nxt = scan_idx_r + IDX_W'(1);
          cmp_vld_nxt  = 1'b1;
          cmp_idx_nxt  = scan_idx_r;
          if (scan_idx_r == LAST_IDX) begin
            scan_on_nxt = 1'b0;
          end
        end
        if (cmp_vld_r && !rd_valid && !free_found_r) begin
          free_found_nxt = 1'b1;
          free_idx_nxt   = cmp_idx_r;
        end
        if (hit) begin
          cmp_vld_nxt = 1'b0;
          scan_on_nxt = 1'b0;
          if (drain_mode_r) begin
            hit_nxt      = rd_entry;
            hit_slot_nxt = cmp_idx_r;
            state_nxt    = S_DRAIN;
          end else begin
            res_status_nxt = ST_DUP;
            state_nxt      = S_EMIT;
          end
        end else if (scan_end) begin
          cmp_vld_nxt = 1'b0;
          state_nxt   = S_EMIT;
          if (!drain_mode_r) begin
            if (free_now) begin
              store_ctl.wr_en = 1'b1;
              res_status_nxt  = ST_HELD;
            end else begin
              res_status_nxt  = ST_FULL;
            end
          end
        end
      end

      S_DRAIN: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_status_nxt  = res_status_r;
          out_handle_nxt  = res_handle_r;
          out_length_nxt  = res_length_r;
          out_seq_nxt     = res_seq_r;
          out_acked_nxt   = res_acked_r;
          out_last_nxt    = 1'b0;
          res_status_nxt  = ST_RELEASED;
          res_handle_nxt  = hit_r.handle;
          res_length_nxt  = hit_r.length;
          res_seq_nxt     = expected_r;
          res_acked_nxt   = expected_r;
          expected_nxt    = expected_r + SEQ_W'(1);
          store_ctl.clr_en = 1'b1;
          store_wr_idx    = hit_slot_r;
          scan_idx_nxt    = '0;
          scan_on_nxt     = 1'b1;
          free_found_nxt  = 1'b0;
          state_nxt       = S_SCAN;
        end
      end

      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_handle_nxt = res_handle_r;
          out_length_nxt = res_length_r;
          out_seq_nxt    = res_seq_r;
          out_acked_nxt  = res_acked_r;
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      expected_r   <= '0;
      scan_on_r    <= 1'b0;
      cmp_vld_r    <= 1'b0;
      free_found_r <= 1'b0;
      drain_mode_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      expected_r   <= expected_nxt;
      scan_on_r    <= scan_on_nxt;
      cmp_vld_r    <= cmp_vld_nxt;
      free_found_r <= free_found_nxt;
      drain_mode_r <= drain_mode_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    seq_r        <= seq_nxt;
    handle_r     <= handle_nxt;
    length_r     <= length_nxt;
    scan_idx_r   <= scan_idx_nxt;
    cmp_idx_r    <= cmp_idx_nxt;
    free_idx_r   <= free_idx_nxt;
    hit_r        <= hit_nxt;
    hit_slot_r   <= hit_slot_nxt;
    res_status_r <= res_status_nxt;
    res_handle_r <= res_handle_nxt;
    res_length_r <= res_length_nxt;
    res_seq_r    <= res_seq_nxt;
    res_acked_r  <= res_acked_nxt;
    out_status_r <= out_status_nxt;
    out_handle_r <= out_handle_nxt;
    out_length_r <= out_length_nxt;
    out_seq_r    <= out_seq_nxt;
    out_acked_r  <= out_acked_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign in_chan.ready          = (state_r == S_IDLE);
  assign out_chan.valid         = out_valid_r;
  assign out_chan.status        = out_status_r;
  assign out_chan.out_handle    = out_handle_r;
  assign out_chan.out_length    = out_length_r;
  assign out_chan.out_seq       = out_seq_r;
  assign out_chan.acked_through = out_acked_r;
  assign out_chan.last          = out_last_r;

  // only a release can be followed by more rows of the same message
  a_single_row_final: assert property (
    @(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r != ST_RELEASED)) |-> out_last_r
  ) else $error("non-release row without last");

  // a released row acknowledges exactly its own sequence number
  a_release_acked: assert property (
    @(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r == ST_RELEASED)) |-> (out_acked_r == out_seq_r)
  ) else $error("released row acked_through mismatch");

  // expected number only ever steps by one
  a_expected_step: assert property (
    @(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && (expected_r != $past(expected_r)))
      |-> (expected_r == $past(expected_r) + SEQ_W'(1))
  ) else $error("expected number jumped");

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// in-order delivery check for sequence_reorder_buffer
// ----------------------------------------------------------------------------
// Sends sequenced messages: a directed opening (release, stale repeat, hold,
// duplicate, full store, longest drain), then shuffled windows of numbers
// with repeats mixed in. Large windows overflow the store and are resent in
// order. A mirror of the holding store predicts every result row, and each
// row taken from the output channel is checked against it. Both channels
// idle at random, and the output side holds off for long stretches.
// ----------------------------------------------------------------------------
module testbench import sro_pkg::*; ();

  localparam int DEPTH          = HOLD_DEPTH_DEF;
  localparam int TOTAL_MSGS     = 320;
  localparam int HOLDOFF_CYCLES = 400;
  localparam int IDLE_LIMIT     = 4000;
  localparam int TAIL_CYCLES    = 4 * (DEPTH + 4);

  typedef struct {
    logic [SEQ_W-1:0]    seq;
    logic [HANDLE_W-1:0] handle;
    logic [LENGTH_W-1:0] length;
  } msg_t;

  typedef struct {
    status_t             status;
    logic [HANDLE_W-1:0] handle;
    logic [LENGTH_W-1:0] length;
    logic [SEQ_W-1:0]    seq;
    logic [SEQ_W-1:0]    acked;
    logic                last;
  } row_t;

  logic clk = 1'b0;
  logic rst_n;

  sro_in_if  in_chan ();
  sro_out_if out_chan ();

  sequence_reorder_buffer u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // store mirror
  logic [SEQ_W-1:0]    next_seq;
  logic                slot_busy [DEPTH];
  logic [SEQ_W-1:0]    slot_seq [DEPTH];
  logic [HANDLE_W-1:0] slot_handle [DEPTH];
  logic [LENGTH_W-1:0] slot_length [DEPTH];

  msg_t pending_msgs [$];
  row_t expected_rows [$];

  msg_t        cur_msg;
  logic        in_busy = 1'b0;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  int unsigned holdoff_left = 0;
  logic [1:0]  holdoff_armed = 2'b00;
  int          msgs_accepted = 0;
  int          msgs_queued = 0;
  int          rows_seen = 0;
  int          mismatches = 0;
  int          max_drain = 0;
  int          idle_cycles = 0;
  int          status_count [5] = '{default: 0};
  logic        calm;

  assign calm = (msgs_accepted >= 100) && (msgs_accepted < 150);

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void queue_msg(logic [SEQ_W-1:0] seq, logic [HANDLE_W-1:0] handle,
                                    logic [LENGTH_W-1:0] length);
    msg_t m;
    m.seq = seq;
    m.handle = handle;
    m.length = length;
    pending_msgs.insert(pending_msgs.size(), m);
    msgs_queued++;
  endfunction

  function automatic int find_slot(logic [SEQ_W-1:0] seq);
    for (int i = 0; i < DEPTH; i++) begin
      if (slot_busy[i] && slot_seq[i] == seq) return i;
    end
    return -1;
  endfunction

  function automatic row_t make_row(status_t st, logic [HANDLE_W-1:0] handle,
                                    logic [LENGTH_W-1:0] length, logic [SEQ_W-1:0] seq);
    row_t r;
    r.status = st;
    r.handle = handle;
    r.length = length;
    r.seq = seq;
    r.acked = next_seq - 1'b1;
    r.last = 1'b0;
    return r;
  endfunction

  function automatic void reorder_predict(msg_t m);
    row_t r;
    int   slot;
    int   rows;
    int   free_slot;
    rows = 1;
    if (m.seq < next_seq) begin
      r = make_row(ST_STALE, '0, '0, '0);
    end else if (m.seq == next_seq) begin
      next_seq++;
      r = make_row(ST_RELEASED, m.handle, m.length, m.seq);
      slot = find_slot(next_seq);
      while (rows < 1 + DEPTH && slot >= 0) begin
        expected_rows.insert(expected_rows.size(), r);
        slot_busy[slot] = 1'b0;
        next_seq++;
        r = make_row(ST_RELEASED, slot_handle[slot], slot_length[slot], slot_seq[slot]);
        rows++;
        slot = find_slot(next_seq);
      end
    end else if (find_slot(m.seq) >= 0) begin
      r = make_row(ST_DUP, '0, '0, '0);
    end else begin
      free_slot = -1;
      for (int i = DEPTH - 1; i >= 0; i--) begin
        if (!slot_busy[i]) free_slot = i;
      end
      if (free_slot >= 0) begin
        slot_busy[free_slot] = 1'b1;
        slot_seq[free_slot] = m.seq;
        slot_handle[free_slot] = m.handle;
        slot_length[free_slot] = m.length;
        r = make_row(ST_HELD, '0, '0, '0);
      end else begin
        r = make_row(ST_FULL, '0, '0, '0);
      end
    end
    r.last = 1'b1;
    expected_rows.insert(expected_rows.size(), r);
    if (rows > max_drain) max_drain = rows;
  endfunction

  // driver
  always @(posedge clk) begin : source_drive
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
    end else begin
      if (in_chan.valid && in_chan.ready) begin
        reorder_predict(cur_msg);
        msgs_accepted <= msgs_accepted + 1;
        in_busy = 1'b0;
      end
      if (!in_busy) begin
        if (gap_left > 0 && !calm) begin
          gap_left--;
        end else if (pending_msgs.size() > 0) begin
          cur_msg = pending_msgs.pop_front();
          in_busy = 1'b1;
          in_chan.seq_number <= cur_msg.seq;
          in_chan.payload_handle <= cur_msg.handle;
          in_chan.payload_length <= cur_msg.length;
          gap_left = pick_gap();
        end
      end
      in_chan.valid <= in_busy;
    end
  end

  // receiver stalls, with long hold-offs so the block backs up
  always @(posedge clk) begin : sink_ready
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else begin
      if (!holdoff_armed[0] && msgs_accepted >= 40) begin
        holdoff_armed[0] = 1'b1;
        holdoff_left = HOLDOFF_CYCLES;
      end
      if (!holdoff_armed[1] && msgs_accepted >= 220) begin
        holdoff_armed[1] = 1'b1;
        holdoff_left = HOLDOFF_CYCLES;
      end
      if (holdoff_left > 0) begin
        holdoff_left--;
        out_chan.ready <= 1'b0;
      end else if (calm) begin
        out_chan.ready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  // monitor
  always @(posedge clk) begin : row_check
    row_t want;
    logic bad;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      rows_seen++;
      if (out_chan.status <= ST_FULL) status_count[out_chan.status]++;
      if (expected_rows.size() == 0) begin
        if (mismatches < 10) begin
          $display("%0t: unexpected row status %0d seq %0h acked %0h", $realtime,
                   out_chan.status, out_chan.out_seq, out_chan.acked_through);
        end
        mismatches++;
      end else begin
        want = expected_rows.pop_front();
        bad = (out_chan.status !== want.status) || (out_chan.out_handle !== want.handle) ||
              (out_chan.out_length !== want.length) || (out_chan.out_seq !== want.seq) ||
              (out_chan.acked_through !== want.acked) || (out_chan.last !== want.last);
        if (bad) begin
          if (mismatches < 10) begin
            $display("%0t: row mismatch", $realtime);
            $display("  expected status %0d handle %0h length %0h seq %0h acked %0h last %0b",
                     want.status, want.handle, want.length, want.seq, want.acked, want.last);
            $display("  actual   status %0d handle %0h length %0h seq %0h acked %0h last %0b",
                     out_chan.status, out_chan.out_handle, out_chan.out_length,
                     out_chan.out_seq, out_chan.acked_through, out_chan.last);
          end
          mismatches++;
        end
      end
    end
  end

  // watchdog on cycles with no transaction on either channel
  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int unsigned base;
    int unsigned w;
    int unsigned j;
    int unsigned tmp;
    int unsigned order [22];

    rst_n = 1'b0;
    in_chan.valid = 1'b0;
    in_chan.seq_number = '0;
    in_chan.payload_handle = '0;
    in_chan.payload_length = '0;
    out_chan.ready = 1'b0;
    next_seq = '0;
    for (int i = 0; i < DEPTH; i++) begin
      slot_busy[i] = 1'b0;
      slot_seq[i] = '0;
      slot_handle[i] = '0;
      slot_length[i] = '0;
    end

    // release, stale repeat, hold, duplicate, drain of two
    queue_msg(32'd0, 16'h0000, 16'h0000);
    queue_msg(32'd0, 16'hFFFF, 16'hFFFF);
    queue_msg(32'd3, 16'hFFFF, 16'h0000);
    queue_msg(32'd3, 16'h1234, 16'h5678);
    queue_msg(32'd2, 16'h0000, 16'hFFFF);
    queue_msg(32'd1, 16'hA5A5, 16'h5A5A);
    // fill every slot, overflow, then drain the whole store
    for (int s = 5; s <= 20; s++) begin
      queue_msg(SEQ_W'(s), HANDLE_W'($urandom), LENGTH_W'($urandom));
    end
    queue_msg(32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
    queue_msg(32'd4, 16'h8001, 16'h7FFE);
    base = 21;

    while (msgs_queued < TOTAL_MSGS) begin
      w = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 22) : $urandom_range(1, 12);
      for (int i = 0; i < w; i++) order[i] = base + i;
      for (int i = w - 1; i > 0; i--) begin
        j = $urandom_range(0, i);
        tmp = order[i];
        order[i] = order[j];
        order[j] = tmp;
      end
      for (int i = 0; i < w; i++) begin
        queue_msg(order[i], HANDLE_W'($urandom), LENGTH_W'($urandom));
        if (i > 0 && $urandom_range(0, 5) == 0) begin
          queue_msg(order[$urandom_range(0, i - 1)], HANDLE_W'($urandom),
                    LENGTH_W'($urandom));
        end
        if ($urandom_range(0, 7) == 0) begin
          queue_msg($urandom_range(0, base - 1), HANDLE_W'($urandom), LENGTH_W'($urandom));
        end
      end
      // overflowed windows are retransmitted in order
      if (w > DEPTH) begin
        for (int i = 0; i < w; i++) begin
          queue_msg(base + i, HANDLE_W'($urandom), LENGTH_W'($urandom));
        end
      end
      base += w;
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    @(negedge clk);
    while (!((pending_msgs.size() == 0 && !in_busy && expected_rows.size() == 0) ||
             idle_cycles >= IDLE_LIMIT)) begin
      @(negedge clk);
    end
    if (idle_cycles < IDLE_LIMIT) repeat (TAIL_CYCLES) @(negedge clk);

    $display("covered %0d messages, %0d rows: %0d released, %0d stale, %0d held, %0d dup, %0d full",
             msgs_accepted, rows_seen, status_count[ST_RELEASED], status_count[ST_STALE],
             status_count[ST_HELD], status_count[ST_DUP], status_count[ST_FULL]);
    $display("longest drain %0d rows for one message, %0d mismatches, idle limit %0s",
             max_drain, mismatches, (idle_cycles >= IDLE_LIMIT) ? "hit" : "not hit");
    if (idle_cycles < IDLE_LIMIT && mismatches == 0 && expected_rows.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### files.f
rtl/sro_pkg.sv
rtl/sro_in_if.sv
rtl/sro_out_if.sv
rtl/sro_hold_store.sv
rtl/sequence_reorder_buffer.sv
tb/testbench.sv
